### rtl/core/rgb_led_pattern_sequencer_assert.svh
`ifndef RGB_LED_PATTERN_SEQUENCER_ASSERT_SVH
`define RGB_LED_PATTERN_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define RLPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlps check failed: now");

// next-cycle implication, sampled on clk, off during rst
`define RLPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlps check failed: next");

`endif

### rtl/core/rlps_pkg.sv
package rlps_pkg;

  // pin level bits
  localparam int unsigned PinRed   = 0;
  localparam int unsigned PinGreen = 1;
  localparam int unsigned PinBlue  = 2;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_CLICK = 3'd1,
    OP_ERROR = 3'd2,
    OP_BLINK = 3'd3,
    OP_OFF   = 3'd4,
    OP_STOP  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    REG_CLICK_HOLD   = 3'd0,
    REG_ERROR_HOLD   = 3'd1,
    REG_FLASH_PERIOD = 3'd2,
    REG_LOOP_PERIOD  = 3'd3,
    REG_ERROR_LIMIT  = 3'd4,
    REG_BLINK_LIMIT  = 3'd5
  } reg_idx_t;

  localparam logic [1:0] ERR_STEADY = 2'd1;
  localparam logic [1:0] ERR_FLASH  = 2'd2;

  localparam logic [2:0] COL_NONE   = 3'd0;
  localparam logic [2:0] COL_RED    = 3'd1;
  localparam logic [2:0] COL_GREEN  = 3'd2;
  localparam logic [2:0] COL_BLUE   = 3'd3;
  localparam logic [2:0] COL_PURPLE = 3'd4;
  localparam logic [2:0] COL_CYAN   = 3'd5;
  localparam logic [2:0] COL_WHITE  = 3'd6;

  localparam logic [15:0] CLICK_HOLD_RST   = 16'd500;
  localparam logic [15:0] ERROR_HOLD_RST   = 16'd2000;
  localparam logic [15:0] FLASH_PERIOD_RST = 16'd200;
  localparam logic [15:0] LOOP_PERIOD_RST  = 16'd400;
  localparam logic [3:0]  ERROR_LIMIT_RST  = 4'd4;
  localparam logic [3:0]  BLINK_LIMIT_RST  = 4'd6;

  typedef struct packed {
    logic [15:0] click_hold_ms;
    logic [15:0] error_hold_ms;
    logic [15:0] flash_period_ms;
    logic [15:0] loop_period_ms;
    logic [3:0]  error_toggle_limit;
    logic [3:0]  blink_toggle_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [2:0] color;
    logic       loop_mode;
    logic [1:0] error_kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] pins;
    logic       busy;
  } res_t;

  typedef struct packed {
    logic        running;
    logic        click_active;
    logic        error_active;
    logic        blink_active;
    logic [1:0]  error_mode;
    logic [3:0]  toggle_count;
    logic        phase_on;
    logic [2:0]  blink_color;
    logic        blink_forever;
    logic [15:0] elapsed_ms;
    logic [2:0]  pin_levels;
  } state_t;

  // pin pattern for a colour code; the unused code keeps the current pins
  function automatic logic [2:0] color_pins(input logic [2:0] col, input logic [2:0] cur);
    logic [2:0] p;
    p = cur;
    case (col)
      COL_NONE:   p = 3'b000;
      COL_RED:    p = 3'b001;
      COL_GREEN:  p = 3'b010;
      COL_BLUE:   p = 3'b100;
      COL_PURPLE: p = 3'b101;
      COL_CYAN:   p = 3'b110;
      COL_WHITE:  p = 3'b111;
      default:    p = cur;
    endcase
    return p;
  endfunction

endpackage

### rtl/core/rlps_ifs.sv
interface rlps_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [2:0] color;
  logic       loop_mode;
  logic [1:0] error_kind;

  modport source (output valid, operation, color, loop_mode, error_kind, input ready);
  modport sink   (input valid, operation, color, loop_mode, error_kind, output ready);
endinterface

interface rlps_res_if;
  logic valid;
  logic ready;
  logic red_on;
  logic green_on;
  logic blue_on;
  logic busy_res;

  modport source (output valid, red_on, green_on, blue_on, busy_res, input ready);
  modport sink   (input valid, red_on, green_on, blue_on, busy_res, output ready);
endinterface

### rtl/core/rlps_cfg.sv
module rlps_cfg (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output rlps_pkg::cfg_t  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.click_hold_ms      <= rlps_pkg::CLICK_HOLD_RST;
      cfg.error_hold_ms      <= rlps_pkg::ERROR_HOLD_RST;
      cfg.flash_period_ms    <= rlps_pkg::FLASH_PERIOD_RST;
      cfg.loop_period_ms     <= rlps_pkg::LOOP_PERIOD_RST;
      cfg.error_toggle_limit <= rlps_pkg::ERROR_LIMIT_RST;
      cfg.blink_toggle_limit <= rlps_pkg::BLINK_LIMIT_RST;
    end else if (cfg_we) begin
      case (rlps_pkg::reg_idx_t'(cfg_index))
        rlps_pkg::REG_CLICK_HOLD:   cfg.click_hold_ms      <= cfg_data;
        rlps_pkg::REG_ERROR_HOLD:   cfg.error_hold_ms      <= cfg_data;
        rlps_pkg::REG_FLASH_PERIOD: cfg.flash_period_ms    <= cfg_data;
        rlps_pkg::REG_LOOP_PERIOD:  cfg.loop_period_ms     <= cfg_data;
        rlps_pkg::REG_ERROR_LIMIT:  cfg.error_toggle_limit <= cfg_data[3:0];
        rlps_pkg::REG_BLINK_LIMIT:  cfg.blink_toggle_limit <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/rlps_seq.sv
module rlps_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  rlps_pkg::cmd_t  cmd,
  input  rlps_pkg::cfg_t  cfg,
  output rlps_pkg::res_t  res_next
);

  rlps_pkg::state_t st;
  rlps_pkg::state_t st_next;

  always_comb begin
    logic done;
    st_next = st;
    done    = 1'b0;
    case (rlps_pkg::op_t'(cmd.operation))
      rlps_pkg::OP_TICK: begin
        if (st_next.elapsed_ms != 16'hFFFF) st_next.elapsed_ms = st_next.elapsed_ms + 16'd1;
        if (st.running) begin
          if (st_next.click_active) begin
            if (st_next.elapsed_ms > cfg.click_hold_ms) begin
              st_next.pin_levels   = 3'b000;
              st_next.click_active = 1'b0;
              st_next.running      = 1'b0;
              done                 = 1'b1;
            end else begin
              st_next.pin_levels = rlps_pkg::color_pins(rlps_pkg::COL_PURPLE,
                                                        st_next.pin_levels);
            end
          end
          if (!done && st_next.error_active) begin
            if (st_next.error_mode == rlps_pkg::ERR_STEADY) begin
              if (st_next.elapsed_ms > cfg.error_hold_ms) begin
                st_next.pin_levels   = 3'b000;
                st_next.error_active = 1'b0;
                st_next.running      = 1'b0;
                done                 = 1'b1;
              end else begin
                st_next.pin_levels = rlps_pkg::color_pins(rlps_pkg::COL_RED,
                                                          st_next.pin_levels);
              end
            end else if (st_next.error_mode == rlps_pkg::ERR_FLASH) begin
              if (st_next.toggle_count == cfg.error_toggle_limit) begin
                st_next.error_active = 1'b0;
                st_next.running      = 1'b0;
              end
              if (st_next.elapsed_ms > cfg.flash_period_ms &&
                  st_next.toggle_count < cfg.error_toggle_limit) begin
                st_next.toggle_count = st_next.toggle_count + 4'd1;
                st_next.phase_on     = !st_next.phase_on;
                st_next.elapsed_ms   = 16'd0;
              end
              st_next.pin_levels = st_next.phase_on ? 3'b001 : 3'b000;
            end
          end
          if (!done && st_next.blink_active) begin
            if (!st_next.blink_forever) begin
              if (st_next.toggle_count == cfg.blink_toggle_limit) begin
                st_next.blink_active = 1'b0;
                st_next.running      = 1'b0;
              end
              if (st_next.elapsed_ms > cfg.flash_period_ms &&
                  st_next.toggle_count < cfg.blink_toggle_limit) begin
                st_next.toggle_count = st_next.toggle_count + 4'd1;
                st_next.phase_on     = !st_next.phase_on;
                st_next.elapsed_ms   = 16'd0;
              end
            end else if (st_next.elapsed_ms > cfg.loop_period_ms) begin
              st_next.phase_on   = !st_next.phase_on;
              st_next.elapsed_ms = 16'd0;
            end
            st_next.pin_levels = rlps_pkg::color_pins(
                st_next.phase_on ? st_next.blink_color : rlps_pkg::COL_NONE,
                st_next.pin_levels);
          end
        end
      end
      rlps_pkg::OP_CLICK: begin
        st_next.elapsed_ms   = 16'd0;
        st_next.click_active = 1'b1;
        st_next.error_active = 1'b0;
        st_next.blink_active = 1'b0;
        st_next.running      = 1'b1;
      end
      rlps_pkg::OP_ERROR: begin
        st_next.elapsed_ms   = 16'd0;
        st_next.error_active = 1'b1;
        st_next.error_mode   = cmd.error_kind;
        st_next.toggle_count = 4'd0;
        st_next.click_active = 1'b0;
        st_next.blink_active = 1'b0;
        st_next.running      = 1'b1;
      end
      rlps_pkg::OP_BLINK: begin
        st_next.blink_color   = cmd.color;
        st_next.elapsed_ms    = 16'd0;
        st_next.blink_active  = 1'b1;
        st_next.blink_forever = cmd.loop_mode;
        st_next.toggle_count  = 4'd0;
        st_next.click_active  = 1'b0;
        st_next.error_active  = 1'b0;
        st_next.running       = 1'b1;
      end
      rlps_pkg::OP_OFF: begin
        st_next.pin_levels = 3'b000;
      end
      rlps_pkg::OP_STOP: begin
        st_next.blink_forever = 1'b0;
        st_next.running       = 1'b0;
        st_next.pin_levels    = 3'b000;
      end
      default: ;
    endcase
  end

  assign res_next.pins = st_next.pin_levels;
  assign res_next.busy = st_next.running;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

endmodule

### rtl/core/rgb_led_pattern_sequencer.sv
// a command's result is registered on acceptance and shows on res in the next cycle
// throughput: one command per cycle while res.ready is high or no result is held
// the result register frees cmd.ready as soon as its held result is taken
// rst (synchronous, active high) clears all pattern state, pin levels included,
// and reloads every configuration register with its default; res_q is not reset
module rgb_led_pattern_sequencer (
  input  logic        clk,
  input  logic        rst,
  rlps_cmd_if.sink    cmd,
  rlps_res_if.source  res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  `include "rgb_led_pattern_sequencer_assert.svh"

  rlps_pkg::cfg_t cfg;
  rlps_pkg::cmd_t cmd_in;
  rlps_pkg::res_t res_next;
  rlps_pkg::res_t res_q;
  logic           res_valid;
  logic           take;

  assign cmd_in.operation  = cmd.operation;
  assign cmd_in.color      = cmd.color;
  assign cmd_in.loop_mode  = cmd.loop_mode;
  assign cmd_in.error_kind = cmd.error_kind;

  assign cmd.ready = !res_valid || res.ready;
  assign take      = cmd.valid && cmd.ready;

  rlps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rlps_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .cmd      (cmd_in),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res_next;
    end
  end

  assign res.valid    = res_valid;
  assign res.red_on   = res_q.pins[rlps_pkg::PinRed];
  assign res.green_on = res_q.pins[rlps_pkg::PinGreen];
  assign res.blue_on  = res_q.pins[rlps_pkg::PinBlue];
  assign res.busy_res = res_q.busy;

  `RLPS_ASSERT_NOW(a_ready_when_empty, !res_valid, cmd.ready)
  `RLPS_ASSERT_NEXT(a_stop_idles,
    take && cmd.operation == 3'(rlps_pkg::OP_STOP),
    res.valid && !res.busy_res && !res.red_on && !res.green_on && !res.blue_on)
  `RLPS_ASSERT_NEXT(a_off_dark,
    take && cmd.operation == 3'(rlps_pkg::OP_OFF),
    res.valid && !res.red_on && !res.green_on && !res.blue_on)
  `RLPS_ASSERT_NEXT(a_start_busy,
    take && (cmd.operation == 3'(rlps_pkg::OP_CLICK) ||
             cmd.operation == 3'(rlps_pkg::OP_ERROR) ||
             cmd.operation == 3'(rlps_pkg::OP_BLINK)),
    res.valid && res.busy_res)

endmodule
